[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define ODE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge
`define ODE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/ode_pkg.sv]
// types and codes of the ordered deque engine
// no dependencies
`timescale 1ns / 1ps

package ode_pkg;

  localparam int ValueW = 32;
  localparam int CountOutW = 7;

  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_SORTED     = 3'd2;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [2:0] MODE_POP_BACK   = 3'd4;
  localparam logic [2:0] MODE_REMOVE     = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic [2:0] mode_t;
  typedef logic [1:0] status_t;
  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [CountOutW-1:0] count_out_t;

endpackage

[rtl/core/ode_if.sv]
// beat channels of the ordered deque engine
// depends on ode_pkg
`timescale 1ns / 1ps

interface ode_in_if;
  logic              valid;
  logic              ready;
  ode_pkg::mode_t    mode;
  ode_pkg::value_t   value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

interface ode_out_if;
  logic                  valid;
  logic                  ready;
  ode_pkg::status_t      status;
  ode_pkg::value_t       removed_value;
  ode_pkg::count_out_t   entry_count;

  modport source (output valid, output status, output removed_value, output entry_count,
                  input ready);
  modport sink (input valid, input status, input removed_value, input entry_count,
                output ready);
endinterface

[rtl/core/ode_ram.sv]
// generic simple dual-port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps

module ode_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/ordered_deque_engine.sv]
// Bounded deque of signed 32-bit values with sorted insert, kept in one ram with
// entry 0 as head. An item reads no entry when a push is refused, on an empty pop or
// remove and in an unused mode; a push at the back or into an empty store only writes.
// Other items read entries, the worst being a sorted insert that shifts: the search
// reads and compares one entry at a time (S_SRD, S_SCMP) and every shift moves one
// entry (S_UPR, S_UPW) through the single read and single write port of the entry ram.
// A finished result waits in an output register while the next item is taken; the next
// result then waits in the last state, holding the input, until that register is taken.
// No clearing pass after reset.
`timescale 1ns / 1ps

module ordered_deque_engine #(
  parameter int CAPACITY = 64
) (
  input logic clk,
  input logic rst_n,
  ode_in_if.sink    in_ch,
  ode_out_if.source out_ch
);
  import ode_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SRD  = 9'b000000010,
    S_SCMP = 9'b000000100,
    S_UPR  = 9'b000001000,
    S_UPW  = 9'b000010000,
    S_INS  = 9'b000100000,
    S_DNR  = 9'b001000000,
    S_DNW  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  mode_t           mode_r, mode_nxt;
  value_t          val_r, val_nxt;
  status_t         status_r, status_nxt;
  value_t          removed_r, removed_nxt;

  logic            out_valid_r;
  status_t         out_status_r;
  value_t          out_removed_r;
  count_out_t      out_count_r;
  logic            out_load;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]     ram_wdata, rd;
  value_t          rd_s;
  logic [CW-1:0]   k1, cnt_m1;

  ode_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  assign rd_s   = $signed(rd);
  assign k1     = k_r + CW'(1);
  assign cnt_m1 = count_r - CW'(1);

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.removed_value = out_removed_r;
  assign out_ch.entry_count   = out_count_r;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    k_nxt       = k_r;
    pos_nxt     = pos_r;
    mode_nxt    = mode_r;
    val_nxt     = val_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    ram_we      = 1'b0;
    ram_waddr   = k_r[AW-1:0];
    ram_wdata   = rd;
    ram_raddr   = k_r[AW-1:0];
    out_load    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt    = in_ch.mode;
          val_nxt     = in_ch.value;
          status_nxt  = ST_OK;
          removed_nxt = '0;
          state_nxt   = S_DONE;
          case (in_ch.mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_SORTED: begin
              if (count_r == CW'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else if (in_ch.mode == MODE_PUSH_BACK || count_r == '0) begin
                pos_nxt   = count_r;
                state_nxt = S_INS;
              end else if (in_ch.mode == MODE_PUSH_FRONT) begin
                pos_nxt   = '0;
                k_nxt     = cnt_m1;
                state_nxt = S_UPR;
              end else begin
                k_nxt     = '0;
                state_nxt = S_SRD;
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK, MODE_REMOVE: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                k_nxt     = (in_ch.mode == MODE_POP_BACK) ? cnt_m1 : '0;
                state_nxt = S_SRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SRD: begin
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        case (mode_r)
          MODE_SORTED: begin
            if ((k_r == '0 && val_r < rd_s) || (k_r != '0 && !(rd_s < val_r))) begin
              pos_nxt   = k_r;
              k_nxt     = cnt_m1;
              state_nxt = S_UPR;
            end else if (k1 == count_r) begin
              pos_nxt   = count_r;
              state_nxt = S_INS;
            end else begin
              k_nxt     = k1;
              state_nxt = S_SRD;
            end
          end
          MODE_REMOVE: begin
            if (rd_s == val_r) begin
              removed_nxt = rd_s;
              if (k_r == cnt_m1) begin
                count_nxt = cnt_m1;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_DNR;
              end
            end else if (k1 == count_r) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              k_nxt     = k1;
              state_nxt = S_SRD;
            end
          end
          default: begin
            removed_nxt = rd_s;
            if (k_r == cnt_m1) begin
              count_nxt = cnt_m1;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_DNR;
            end
          end
        endcase
      end
      S_UPR: begin
        state_nxt = S_UPW;
      end
      S_UPW: begin
        ram_we    = 1'b1;
        ram_waddr = k1[AW-1:0];
        if (k_r == pos_r) begin
          state_nxt = S_INS;
        end else begin
          k_nxt     = k_r - CW'(1);
          state_nxt = S_UPR;
        end
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[AW-1:0];
        ram_wdata = val_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_DNR: begin
        ram_raddr = k1[AW-1:0];
        state_nxt = S_DNW;
      end
      S_DNW: begin
        ram_we = 1'b1;
        if (k1 == cnt_m1) begin
          count_nxt = cnt_m1;
          state_nxt = S_DONE;
        end else begin
          k_nxt     = k1;
          state_nxt = S_DNR;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    pos_r     <= pos_nxt;
    mode_r    <= mode_nxt;
    val_r     <= val_nxt;
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
    if (out_load) begin
      out_status_r  <= status_r;
      out_removed_r <= removed_r;
      out_count_r   <= CountOutW'(count_r);
    end
  end

  `ODE_ASSERT(a_count_bound, count_r <= CW'(CAPACITY), "count above capacity")
  `ODE_ASSERT(a_count_step, (state_r == S_IDLE) |=> (count_r == $past(count_r)),
              "count moved on accept")
  `ODE_ASSERT(a_full_count, (out_valid_r && out_status_r == ST_FULL) |->
              (out_count_r == CountOutW'(CAPACITY)), "refused push while not full")
  `ODE_ASSERT(a_fail_no_value, (out_valid_r && out_status_r != ST_OK) |->
              (out_removed_r == '0), "failed beat carries a value")

endmodule
